### sv/quadratic_root_solver_defines.svh
// Assertion helpers used by the solver top level
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Invariant that must hold at every clock edge out of reset
`define QRS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/qrs_pkg.sv
`default_nettype none
package qrs_pkg;

  // field widths and fixed-point split
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 16;
  localparam int HALF_FRAC = FRAC_BITS / 2;
  localparam int REST_FRAC = FRAC_BITS - HALF_FRAC;
  localparam int RES_W     = 34;

  // discriminant, square root and divider widths
  localparam int D_W    = 2 * COEF_W + 2;
  localparam int DMAG_W = 2 * COEF_W + 1;
  localparam int SQ_W   = (DMAG_W + 2 * HALF_FRAC + 1) / 2;
  localparam int RAD_W  = 2 * SQ_W;
  localparam int REM_W  = SQ_W + 2;
  localparam int NUM_W  = SQ_W + REST_FRAC + 1;
  localparam int DEN_W  = COEF_W + 1;

  // smallest positive quotient magnitude that no longer fits the result
  localparam logic [NUM_W-1:0] RES_LIM = NUM_W'(1) << (RES_W - 1);

  // root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  // which numerators the item needs
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LIN,
    KIND_ONE,
    KIND_TWO
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [1:0]               cnt;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } side_t;

  typedef struct packed {
    logic       neg;
    logic [1:0] cnt;
  } div_tag_t;

endpackage
`default_nettype wire

### sv/qrs_coef_if.sv
`default_nettype none
interface qrs_coef_if import qrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_quad;
  logic signed [COEF_W-1:0] coef_lin;
  logic signed [COEF_W-1:0] coef_const;

  modport source(output valid, coef_quad, coef_lin, coef_const, input ready);
  modport sink(input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface
`default_nettype wire

### sv/qrs_root_if.sv
`default_nettype none
interface qrs_root_if import qrs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              root_count;
  logic signed [RES_W-1:0] root_first;
  logic signed [RES_W-1:0] root_second;

  modport source(output valid, root_count, root_first, root_second, input ready);
  modport sink(input valid, root_count, root_first, root_second, output ready);
endinterface
`default_nettype wire

### sv/quadratic_root_solver.sv
// Quadratic root solver.
// coef (sink): one word holds the signed coefficients coef_quad, coef_lin and
// coef_const of a*x^2 + b*x + c = 0. root (source): one word per input word
// with root_count (none, one, two, infinite) and two Q16 roots, root_second
// being the minus-square-root branch; unused roots read 0.
// Throughput: one word per cycle unless the output stalls. The accepting edge
// loads the first of 63 register stages (2 of products and discriminant, 25
// square-root stages, 1 numerator stage, 34 divider stages, 1 output register).
// The divider depth, one quotient bit per stage over the numerator width, sets
// most of the latency.
// The whole pipeline shares one enable: it moves whenever the output register
// is empty or being taken. While root.ready is low with a word held, every
// stage freezes and coef.ready is low; nothing is dropped or repeated.
// Reset (rst, synchronous) clears all stage valid bits; the block takes a
// word in the first cycle after reset.
`default_nettype none
`include "quadratic_root_solver_defines.svh"
module quadratic_root_solver import qrs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  qrs_coef_if.sink   coef,
  qrs_root_if.source root
);

  logic              en;
  logic              v_f, v_s, v_n, v_d1, v_d2;
  logic [DMAG_W-1:0] dmag;
  side_t             side_f, side_s;
  logic [SQ_W-1:0]   s;

  logic signed [NUM_W:0] b_x, c_x, s_x, base, n1, n2;
  logic signed [DEN_W:0] den_s, den_abs;
  logic signed [NUM_W:0] n1_abs, n2_abs;

  logic [NUM_W-1:0] n1_mag, n2_mag;
  logic [DEN_W-1:0] den_mag;
  div_tag_t         tag1, tag2, tag1_d, tag2_d;
  logic [NUM_W-1:0] q1, q2;

  // global advance: output register empty or being taken
  assign en         = !root.valid || root.ready;
  assign coef.ready = en;

  qrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (coef.valid),
    .a_in     (coef.coef_quad),
    .b_in     (coef.coef_lin),
    .c_in     (coef.coef_const),
    .out_valid(v_f),
    .dmag     (dmag),
    .side     (side_f)
  );

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_f),
    .rad_in   (dmag),
    .side_in  (side_f),
    .out_valid(v_s),
    .root     (s),
    .side_out (side_s)
  );

  // numerators and denominator per case
  assign b_x  = (NUM_W+1)'($signed(side_s.b));
  assign c_x  = (NUM_W+1)'($signed(side_s.c));
  assign s_x  = (NUM_W+1)'(s);
  assign base = -(b_x <<< HALF_FRAC);

  always_comb begin
    n1    = '0;
    n2    = '0;
    den_s = (DEN_W+1)'(1);
    case (side_s.kind)
      KIND_LIN: begin
        n1    = -(c_x <<< FRAC_BITS);
        den_s = (DEN_W+1)'($signed(side_s.b));
      end
      KIND_ONE: begin
        n1    = -(b_x <<< FRAC_BITS);
        den_s = (DEN_W+1)'($signed(side_s.a)) <<< 1;
      end
      KIND_TWO: begin
        n1    = (base + s_x) <<< REST_FRAC;
        n2    = (base - s_x) <<< REST_FRAC;
        den_s = (DEN_W+1)'($signed(side_s.a)) <<< 1;
      end
      default: begin
        n1    = '0;
        n2    = '0;
        den_s = (DEN_W+1)'(1);
      end
    endcase
  end

  assign den_abs = den_s[DEN_W] ? -den_s : den_s;
  assign n1_abs  = n1[NUM_W] ? -n1 : n1;
  assign n2_abs  = n2[NUM_W] ? -n2 : n2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_n <= 1'b0;
    end else if (en) begin
      v_n <= v_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_mag   <= n1_abs[NUM_W-1:0];
      n2_mag   <= n2_abs[NUM_W-1:0];
      den_mag  <= den_abs[DEN_W-1:0];
      tag1.neg <= n1[NUM_W] ^ den_s[DEN_W];
      tag1.cnt <= side_s.cnt;
      tag2.neg <= n2[NUM_W] ^ den_s[DEN_W];
      tag2.cnt <= side_s.cnt;
    end
  end

  qrs_div u_div_first (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_n),
    .num_in   (n1_mag),
    .den_in   (den_mag),
    .tag_in   (tag1),
    .out_valid(v_d1),
    .quo      (q1),
    .tag_out  (tag1_d)
  );

  qrs_div u_div_second (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_n),
    .num_in   (n2_mag),
    .den_in   (den_mag),
    .tag_in   (tag2),
    .out_valid(v_d2),
    .quo      (q2),
    .tag_out  (tag2_d)
  );

  // apply sign and clamp to the result range
  function automatic logic signed [RES_W-1:0] pack_root(
    input logic [NUM_W-1:0] q,
    input logic             neg
  );
    logic signed [NUM_W:0] val;
    val = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (!neg && q >= RES_LIM) begin
      pack_root = {1'b0, {(RES_W-1){1'b1}}};
    end else if (neg && q > RES_LIM) begin
      pack_root = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      pack_root = val[RES_W-1:0];
    end
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      root.valid <= 1'b0;
    end else if (en) begin
      root.valid <= v_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root.root_count  <= tag1_d.cnt;
      root.root_first  <= pack_root(q1, tag1_d.neg);
      root.root_second <= pack_root(q2, tag2_d.neg);
    end
  end

  // checks
  `QRS_ASSERT(a_div_lockstep, v_d1 == v_d2 && (!v_d1 || tag1_d.cnt == tag2_d.cnt),
              "root dividers out of step")
  `QRS_ASSERT(a_none_zero,
              !root.valid || (root.root_count != CNT_NONE && root.root_count != CNT_INF)
              || (root.root_first == '0 && root.root_second == '0),
              "roots not zero without a finite root")
  `QRS_ASSERT(a_second_zero,
              !root.valid || root.root_count == CNT_TWO || root.root_second == '0,
              "second root set without two roots")
  `QRS_ASSERT_NEXT(a_drain, root.valid && root.ready && !v_d1, !root.valid,
                   "output word repeated")

endmodule
`default_nettype wire

### sv/qrs_front.sv
`default_nettype none
module qrs_front import qrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [COEF_W-1:0] a_in,
  input  logic signed [COEF_W-1:0] b_in,
  input  logic signed [COEF_W-1:0] c_in,
  output logic                     out_valid,
  output logic [DMAG_W-1:0]        dmag,
  output side_t                    side
);

  logic                       v1;
  logic signed [COEF_W-1:0]   a1, b1, c1;
  logic signed [2*COEF_W-1:0] bb1, ac1;
  logic signed [D_W-1:0]      d;
  kind_t                      kind_next;
  logic [1:0]                 cnt_next;
  logic [DMAG_W-1:0]          dmag_next;

  // stage 1: the two products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= a_in;
      b1  <= b_in;
      c1  <= c_in;
      bb1 <= b_in * b_in;
      ac1 <= a_in * c_in;
    end
  end

  // stage 2: discriminant and case split
  assign d = D_W'(bb1) - (D_W'(ac1) <<< 2);

  always_comb begin
    kind_next = KIND_NONE;
    cnt_next  = CNT_NONE;
    if (a1 == '0) begin
      if (b1 == '0) begin
        cnt_next = (c1 == '0) ? CNT_INF : CNT_NONE;
      end else begin
        kind_next = KIND_LIN;
        cnt_next  = CNT_ONE;
      end
    end else if (d > 0) begin
      kind_next = KIND_TWO;
      cnt_next  = CNT_TWO;
    end else if (d == '0) begin
      kind_next = KIND_ONE;
      cnt_next  = CNT_ONE;
    end
  end

  assign dmag_next = (kind_next == KIND_TWO) ? d[DMAG_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag      <= dmag_next;
      side.kind <= kind_next;
      side.cnt  <= cnt_next;
      side.a    <= a1;
      side.b    <= b1;
      side.c    <= c1;
    end
  end

endmodule
`default_nettype wire

### sv/qrs_sqrt.sv
`default_nettype none
module qrs_sqrt import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DMAG_W-1:0] rad_in,
  input  side_t             side_in,
  output logic              out_valid,
  output logic [SQ_W-1:0]   root,
  output side_t             side_out
);

  // one result bit per stage, restoring digit recurrence
  logic             src_v    [SQ_W];
  logic [RAD_W-1:0] src_rad  [SQ_W];
  logic [REM_W-1:0] src_rem  [SQ_W];
  logic [SQ_W-1:0]  src_r    [SQ_W];
  side_t            src_side [SQ_W];

  logic             st_v    [SQ_W];
  logic [RAD_W-1:0] st_rad  [SQ_W];
  logic [REM_W-1:0] st_rem  [SQ_W];
  logic [SQ_W-1:0]  st_r    [SQ_W];
  side_t            st_side [SQ_W];

  for (genvar k = 0; k < SQ_W; k++) begin : g_step
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign src_v[k]    = in_valid;
      assign src_rad[k]  = RAD_W'({rad_in, {(2*HALF_FRAC){1'b0}}});
      assign src_rem[k]  = '0;
      assign src_r[k]    = '0;
      assign src_side[k] = side_in;
    end else begin : g_chain
      assign src_v[k]    = st_v[k-1];
      assign src_rad[k]  = st_rad[k-1];
      assign src_rem[k]  = st_rem[k-1];
      assign src_r[k]    = st_r[k-1];
      assign src_side[k] = st_side[k-1];
    end

    assign rs    = {src_rem[k][REM_W-3:0], src_rad[k][RAD_W-1 -: 2]};
    assign trial = {src_r[k], 2'b01};
    assign ge    = (rs >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else if (en) begin
        st_v[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rad[k]  <= src_rad[k] << 2;
        st_rem[k]  <= ge ? (rs - trial) : rs;
        st_r[k]    <= {src_r[k][SQ_W-2:0], ge};
        st_side[k] <= src_side[k];
      end
    end
  end

  assign out_valid = st_v[SQ_W-1];
  assign root      = st_r[SQ_W-1];
  assign side_out  = st_side[SQ_W-1];

endmodule
`default_nettype wire

### sv/qrs_div.sv
`default_nettype none
module qrs_div import qrs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  input  div_tag_t         tag_in,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output div_tag_t         tag_out
);

  // unsigned restoring divider, one quotient bit per stage
  logic             src_v   [NUM_W];
  logic [NUM_W-1:0] src_num [NUM_W];
  logic [DEN_W-1:0] src_rem [NUM_W];
  logic [DEN_W-1:0] src_den [NUM_W];
  div_tag_t         src_tag [NUM_W];

  logic             st_v   [NUM_W];
  logic [NUM_W-1:0] st_num [NUM_W];
  logic [DEN_W-1:0] st_rem [NUM_W];
  logic [DEN_W-1:0] st_den [NUM_W];
  div_tag_t         st_tag [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DEN_W:0] rs;
    logic [DEN_W:0] diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign src_v[k]   = in_valid;
      assign src_num[k] = num_in;
      assign src_rem[k] = '0;
      assign src_den[k] = den_in;
      assign src_tag[k] = tag_in;
    end else begin : g_chain
      assign src_v[k]   = st_v[k-1];
      assign src_num[k] = st_num[k-1];
      assign src_rem[k] = st_rem[k-1];
      assign src_den[k] = st_den[k-1];
      assign src_tag[k] = st_tag[k-1];
    end

    assign rs   = {src_rem[k], src_num[k][NUM_W-1]};
    assign diff = rs - {1'b0, src_den[k]};
    assign ge   = (rs >= {1'b0, src_den[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else if (en) begin
        st_v[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_num[k] <= {src_num[k][NUM_W-2:0], ge};
        st_rem[k] <= ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
        st_den[k] <= src_den[k];
        st_tag[k] <= src_tag[k];
      end
    end
  end

  assign out_valid = st_v[NUM_W-1];
  assign quo       = st_num[NUM_W-1];
  assign tag_out   = st_tag[NUM_W-1];

endmodule
`default_nettype wire

### test/qrs_tb_pkg.sv
package qrs_tb_pkg;
  import qrs_pkg::*;

  // one coefficient word and its expected solution
  typedef struct {
    logic signed [COEF_W-1:0] quad;
    logic signed [COEF_W-1:0] lin;
    logic signed [COEF_W-1:0] cnst;
  } coef_word_t;

  typedef struct {
    logic [1:0]              count;
    logic signed [RES_W-1:0] first;
    logic signed [RES_W-1:0] second;
  } root_word_t;
endpackage

### test/testbench.sv
module testbench;
  import qrs_pkg::*;
  import qrs_tb_pkg::*;

  logic clk;
  logic rst;

  qrs_coef_if coef ();
  qrs_root_if root ();

  quadratic_root_solver DUT (
    .clk (clk),
    .rst (rst),
    .coef(coef.sink),
    .root(root.source)
  );

  // directed row: coefficients plus an optional typed-in answer
  typedef struct {
    int         a, b, c;
    bit         fixed;
    logic [1:0] count;
    longint     first, second;
  } coef_row_t;

  root_word_t  pending_roots[$];
  coef_word_t  stim_words[$];
  int          fail_count;
  int          checked_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          count_seen[4];
  logic        load_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // digit-by-digit floor square root of v
  function automatic longint isqrt(longint v);
    longint r, rem, trial;
    r = 0;
    rem = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 3);
      trial = (r << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        r = (r << 1) | 1;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  // 64-bit signed division truncates toward zero, as required
  function automatic root_word_t solve_quadratic(coef_word_t w);
    root_word_t res;
    longint a, b, c, d, s, base, x1, x2;
    a = w.quad;
    b = w.lin;
    c = w.cnst;
    x1 = 0;
    x2 = 0;
    if (a == 0) begin
      if (b == 0) begin
        res.count = (c == 0) ? CNT_INF : CNT_NONE;
      end else begin
        x1 = (-c * (64'sd1 <<< FRAC_BITS)) / b;
        res.count = CNT_ONE;
      end
    end else begin
      d = b * b - 4 * a * c;
      if (d > 0) begin
        s = isqrt(d << (2 * HALF_FRAC));
        base = -b * (64'sd1 <<< HALF_FRAC);
        x1 = ((base + s) * (64'sd1 <<< REST_FRAC)) / (2 * a);
        x2 = ((base - s) * (64'sd1 <<< REST_FRAC)) / (2 * a);
        res.count = CNT_TWO;
      end else if (d == 0) begin
        x1 = (-b * (64'sd1 <<< FRAC_BITS)) / (2 * a);
        res.count = CNT_ONE;
      end else begin
        res.count = CNT_NONE;
      end
    end
    res.first = x1[RES_W-1:0];
    res.second = x2[RES_W-1:0];
    return res;
  endfunction

  // directed table
  coef_row_t rows[] = '{
    '{0, 0, 0, 1, CNT_INF, 0, 0},
    '{0, 0, 5, 1, CNT_NONE, 0, 0},
    '{0, 0, -32768, 1, CNT_NONE, 0, 0},
    '{0, 2, -4, 1, CNT_ONE, 64'sd131072, 0},
    '{0, -32768, 32767, 0, 0, 0, 0},
    '{0, 1, -32768, 0, 0, 0, 0},
    '{1, 0, -1, 1, CNT_TWO, 64'sd65536, -64'sd65536},
    '{1, -2, 1, 1, CNT_ONE, 64'sd65536, 0},
    '{1, 0, 1, 1, CNT_NONE, 0, 0},
    '{1, -32768, -32768, 0, 0, 0, 0},
    '{-32768, -32768, 32767, 0, 0, 0, 0},
    '{-32768, 32767, -32768, 0, 0, 0, 0},
    '{32767, 32767, 32767, 0, 0, 0, 0},
    '{-32768, -32768, -32768, 0, 0, 0, 0},
    '{1, 32767, 0, 0, 0, 0, 0},
    '{-1, 1, 0, 0, 0, 0, 0},
    '{1, 1, 0, 0, 0, 0, 0},
    '{3, 5, -7, 0, 0, 0, 0},
    '{-5, 3, 11, 0, 0, 0, 0},
    '{16384, -32768, 16384, 0, 0, 0, 0},
    '{1, 1, -32768, 0, 0, 0, 0},
    '{-1, -1, 32767, 0, 0, 0, 0}
  };

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return COEF_W'($urandom_range(0, 8)) - COEF_W'(4);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return 16'sd0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // sender
  initial begin
    coef_word_t w;
    root_word_t ans;
    int a, r;
    rst = 1'b1;
    coef.valid = 1'b0;
    coef.coef_quad = '0;
    coef.coef_lin = '0;
    coef.coef_const = '0;
    fail_count = 0;
    checked_count = 0;
    load_done = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows first, then random words; perfect squares help hit d = 0
    foreach (rows[i]) begin
      w.quad = COEF_W'(rows[i].a);
      w.lin = COEF_W'(rows[i].b);
      w.cnst = COEF_W'(rows[i].c);
      stim_words.push_back(w);
    end
    for (int i = 0; i < 1850; i++) begin
      w.quad = rand_coef();
      w.lin = rand_coef();
      w.cnst = rand_coef();
      if ($urandom_range(0, 9) == 0) begin
        // b^2 = 4ac: pattern b = -2*a*r, c = a*r*r
        a = $urandom_range(1, 60) * ($urandom_range(0, 1) ? 1 : -1);
        r = $urandom_range(0, 20) - 10;
        w.quad = COEF_W'(a);
        w.lin = COEF_W'(-2 * a * r);
        w.cnst = COEF_W'(a * r * r);
      end
      stim_words.push_back(w);
    end

    for (int i = 0; i < stim_words.size(); i++) begin
      if (i == 22 + 600) begin
        send_idle_pct = 63;
        recv_idle_pct = 26;
      end else if (i == 22 + 1200) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (i == 0) begin
        send_idle_pct = 26;
        recv_idle_pct = 63;
      end
      w = stim_words[i];
      if (i < rows.size() && rows[i].fixed) begin
        ans.count = rows[i].count;
        ans.first = rows[i].first[RES_W-1:0];
        ans.second = rows[i].second[RES_W-1:0];
      end else begin
        ans = solve_quadratic(w);
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
        coef.valid <= 1'b0;
        @(posedge clk);
      end
      coef.valid <= 1'b1;
      coef.coef_quad <= w.quad;
      coef.coef_lin <= w.lin;
      coef.coef_const <= w.cnst;
      @(posedge clk);
      while (!coef.ready) @(posedge clk);
      pending_roots.push_back(ans);
    end
    coef.valid <= 1'b0;
    load_done = 1'b1;
  end

  // receiver stall
  initial begin
    root.ready = 1'b0;
    forever begin
      @(posedge clk);
      root.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    root_word_t exp_w;
    if (!rst && root.valid && root.ready) begin
      if (pending_roots.size() == 0) begin
        $error("unexpected result word");
        fail_count++;
      end else begin
        exp_w = pending_roots.pop_front();
        checked_count++;
        count_seen[root.root_count]++;
        if (root.root_count !== exp_w.count) begin
          $error("root_count exp %0d got %0d", exp_w.count, root.root_count);
          fail_count++;
        end
        if (root.root_first !== exp_w.first) begin
          $error("root_first exp %0d got %0d", exp_w.first, root.root_first);
          fail_count++;
        end
        if (root.root_second !== exp_w.second) begin
          $error("root_second exp %0d got %0d", exp_w.second, root.root_second);
          fail_count++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (load_done === 1'b1);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("checked %0d words: none %0d, one %0d, two %0d, infinite %0d",
             checked_count, count_seen[0], count_seen[1], count_seen[2],
             count_seen[3]);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end
endmodule

### filelist.f
+incdir+sv
sv/qrs_pkg.sv
sv/qrs_coef_if.sv
sv/qrs_root_if.sv
sv/qrs_front.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver.sv
test/qrs_tb_pkg.sv
test/testbench.sv
